/* rtl/mvs_pkg.sv */
// Shared types and constants for the mu-law volume scaler.
// No dependencies; imported by every module of the block.
`default_nettype none
package mvs_pkg;

  localparam int CODE_W         = 8;
  localparam int GAIN_W         = 16;
  localparam int GAIN_FRAC_BITS = 12;
  localparam int MAG_W          = 15;                     // largest expanded magnitude 32124
  localparam int PROD_W         = MAG_W + GAIN_W;
  localparam int SCALED_W       = PROD_W - GAIN_FRAC_BITS;

  localparam logic [MAG_W-1:0]  MU_BIAS = MAG_W'(16'h0084);
  localparam logic [MAG_W-1:0]  MU_CLIP = MAG_W'(32635);
  localparam logic [CODE_W-1:0] MU_TRAP = 8'h02;

  localparam logic [GAIN_W-1:0] GAIN_RESET   = GAIN_W'(4096);
  localparam logic              BYPASS_RESET = 1'b1;

  // configuration register indexes
  localparam logic REG_GAIN   = 1'b0;
  localparam logic REG_BYPASS = 1'b1;

  // segment base of the expanded magnitude
  function automatic logic [MAG_W-1:0] seg_base(input logic [2:0] seg);
    logic [MAG_W-1:0] base;
    unique case (seg)
      3'd0:    base = MAG_W'(0);
      3'd1:    base = MAG_W'(132);
      3'd2:    base = MAG_W'(396);
      3'd3:    base = MAG_W'(924);
      3'd4:    base = MAG_W'(1980);
      3'd5:    base = MAG_W'(4092);
      3'd6:    base = MAG_W'(8316);
      default: base = MAG_W'(16764);
    endcase
    return base;
  endfunction

  // request passed from the scale stage to the encode stage
  typedef struct packed {
    logic                bypass;
    logic [CODE_W-1:0]   code;    // original code, used on bypass
    logic                neg;
    logic [SCALED_W-1:0] scaled;  // magnitude * gain >> frac bits
  } mid_t;

endpackage
`default_nettype wire

/* rtl/mulaw_volume_scaler.sv */
// Top level of the mu-law volume scaler: config registers and 3-stage pipeline.
// Depends on mvs_pkg, mvs_scale and mvs_encode.
//
//  channel  | ports                         | contents
//  ---------+-------------------------------+------------------------------
//  input    | in_tvalid/in_tready/in_tdata  | code_in [7:0]
//  result   | out_tvalid/out_tready/out_tdata| code_out [7:0]
//  config   | cfg_wr_en/cfg_index/cfg_wdata | 0: gain [15:0], 1: bypass [0]
//
// One request per cycle sustained while out_tready stays high; an accepted request
// passes the input register, product register and result register in turn, and
// out_tvalid rises once it reaches the result register, from which it is taken.
// Each stage loads when it is empty or the stage after it moves, so a held
// result does not block new requests until all three stages are full.
// rst_n (sync, active low) empties the pipe, gain = 4096 (unity), bypass = 1.
`default_nettype none
module mulaw_volume_scaler (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [7:0]                 in_tdata,   // [7:0] code_in
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [7:0]                      out_tdata,  // [7:0] code_out
  input  wire logic                       cfg_wr_en,
  input  wire logic                       cfg_index,
  input  wire logic [mvs_pkg::GAIN_W-1:0] cfg_wdata
);
  import mvs_pkg::*;

  // config registers
  logic [GAIN_W-1:0] gain_r;
  logic              bypass_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_RESET;
      bypass_r <= BYPASS_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GAIN:   gain_r   <= cfg_wdata;
        REG_BYPASS: bypass_r <= cfg_wdata[0];
        default:    ;
      endcase
    end
  end

  // stage valids and load enables
  logic v1_r, v2_r, v3_r;
  logic ld1, ld2, ld3;

  assign ld3 = !v3_r || out_tready;
  assign ld2 = !v2_r || ld3;
  assign ld1 = !v1_r || ld2;
  assign in_tready = ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_tvalid;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
    end
  end

  // stage 1: input register
  logic [CODE_W-1:0] code_r;
  always_ff @(posedge clk) begin
    if (ld1) code_r <= in_tdata;
  end

  // stage 2: expand and multiply, product register
  mid_t mid_nxt, mid_r;

  mvs_scale u_scale (
    .code   (code_r),
    .gain   (gain_r),
    .bypass (bypass_r),
    .mid    (mid_nxt)
  );

  always_ff @(posedge clk) begin
    if (ld2) mid_r <= mid_nxt;
  end

  // stage 3: clip and encode, result register
  logic [CODE_W-1:0] out_nxt, out_r;

  mvs_encode u_encode (
    .mid  (mid_r),
    .code (out_nxt)
  );

  always_ff @(posedge clk) begin
    if (ld3) out_r <= out_nxt;
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = out_r;

endmodule
`default_nettype wire

/* rtl/mvs_scale.sv */
// Expands a mu-law code to sign and magnitude and applies the gain.
// Depends on mvs_pkg.
`default_nettype none
module mvs_scale (
  input  wire logic [mvs_pkg::CODE_W-1:0] code,
  input  wire logic [mvs_pkg::GAIN_W-1:0] gain,
  input  wire logic                       bypass,
  output mvs_pkg::mid_t                   mid
);
  import mvs_pkg::*;

  logic [CODE_W-1:0] inv;
  logic [2:0]        seg;
  logic [3:0]        mant;
  logic [3:0]        shamt;
  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] prod;

  assign inv   = ~code;
  assign seg   = inv[6:4];
  assign mant  = inv[3:0];
  assign shamt = {1'b0, seg} + 4'd3;
  assign mag   = seg_base(seg) + (MAG_W'(mant) << shamt);
  assign prod  = PROD_W'(mag) * PROD_W'(gain);

  always_comb begin
    mid.bypass = bypass;
    mid.code   = code;
    mid.neg    = inv[7];
    mid.scaled = prod[PROD_W-1:GAIN_FRAC_BITS];
  end

endmodule
`default_nettype wire

/* rtl/mvs_encode.sv */
// Clips, biases and re-encodes a scaled magnitude to mu-law, or passes the original code on bypass.
// Depends on mvs_pkg.
`default_nettype none
module mvs_encode (
  input  wire mvs_pkg::mid_t              mid,
  output logic [mvs_pkg::CODE_W-1:0]      code
);
  import mvs_pkg::*;

  logic [MAG_W-1:0]  mag;
  logic [MAG_W-1:0]  biased;
  logic [7:0]        top;
  logic [2:0]        seg;
  logic [3:0]        mant;
  logic              neg;
  logic [CODE_W-1:0] enc;

  always_comb begin
    if (mid.scaled > SCALED_W'(MU_CLIP)) mag = MU_CLIP;
    else                                 mag = mid.scaled[MAG_W-1:0];
    biased = mag + MU_BIAS;
    top    = biased[14:7];
    // segment = position of the leading one in the top byte
    priority if (top[7]) seg = 3'd7;
    else if (top[6])     seg = 3'd6;
    else if (top[5])     seg = 3'd5;
    else if (top[4])     seg = 3'd4;
    else if (top[3])     seg = 3'd3;
    else if (top[2])     seg = 3'd2;
    else if (top[1])     seg = 3'd1;
    else                 seg = 3'd0;
    mant = 4'(biased >> ({1'b0, seg} + 4'd3));
    // zero result always encodes positive
    neg  = mid.neg && (mid.scaled != '0);
    enc  = ~{neg, seg, mant};
    if (mid.bypass)       code = mid.code;
    else if (enc == '0)   code = MU_TRAP;
    else                  code = enc;
  end

endmodule
`default_nettype wire
